### rtl/kic_pkg.sv
package kic_pkg;

    localparam int unsigned KEY_W   = 8;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned TERM_W  = 7;
    localparam int unsigned STEP_W  = $clog2(DATA_W);

    localparam int unsigned MAX_DIGITS_DEF = 15;
    localparam int unsigned MAX_TERMS_DEF  = 99;

    localparam logic [KEY_W-1:0] ENTER_KEY_RST = 8'd10;
    localparam logic [KEY_W-1:0] KEY_FINISH    = 8'h3D;  // '='
    localparam logic [KEY_W-1:0] KEY_ZERO      = 8'h30;  // '0'
    localparam logic [KEY_W-1:0] KEY_NINE      = 8'h39;  // '9'
    localparam logic [KEY_W-1:0] KEY_OP_FIRST  = 8'h31;  // '1'
    localparam logic [KEY_W-1:0] KEY_OP_LAST   = 8'h34;  // '4'

    typedef logic [1:0] t_op;
    localparam t_op OP_ADD = 2'd0;
    localparam t_op OP_SUB = 2'd1;
    localparam t_op OP_MUL = 2'd2;
    localparam t_op OP_DIV = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_DIV_ZERO = 2'd1;
    localparam t_status ST_NO_NUM   = 2'd2;

    localparam logic PHASE_NUMBER = 1'b0;
    localparam logic PHASE_OP     = 1'b1;

endpackage

### rtl/keypad_integer_calculator.sv
// Channel   | Valid    | Stall    | Payload
// ----------+----------+----------+--------------------------------
// key in    | i_valid  | o_stall  | i_key_code
// result    | o_valid  | i_stall  | o_result_value, o_status
// config    | i_cfg_wr_en (no stall) | i_cfg_wr_data (Enter key)
//
// A digit key, or an operation key below the term limit, is taken without a stall. Enter
// with add or subtract folds in the idle state; multiply and divide run a shared 1-bit
// shift-add / restoring-divide unit (plus a sign-fix step for divide).
// A finishing key moves to the finish state and waits there until the result register is
// free; the input stays stalled meanwhile. The result register holds one
// transaction while i_stall is high, and keys keep flowing behind it.
// Reset (i_rst_n low at a clock edge) clears control and result-valid state; Enter code becomes 10.
module keypad_integer_calculator #(
    parameter int unsigned MAX_DIGITS = kic_pkg::MAX_DIGITS_DEF,
    parameter int unsigned MAX_TERMS  = kic_pkg::MAX_TERMS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [kic_pkg::KEY_W-1:0]         i_key_code,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [kic_pkg::DATA_W-1:0] o_result_value,
    output kic_pkg::t_status                  o_status,
    input  logic                              i_cfg_wr_en,
    input  logic [kic_pkg::KEY_W-1:0]         i_cfg_wr_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    localparam int unsigned W = kic_pkg::DATA_W;

    logic [1:0]                      r_state, n_state;
    logic [kic_pkg::KEY_W-1:0]       r_enter_key, n_enter_key;
    logic                            r_phase, n_phase;
    logic [kic_pkg::DIGIT_W-1:0]     r_digit_cnt, n_digit_cnt;
    logic [W-1:0]                    r_number, n_number;
    logic [kic_pkg::TERM_W-1:0]      r_term_cnt, n_term_cnt;
    logic [W-1:0]                    r_acc, n_acc;
    kic_pkg::t_op                    r_op, n_op;
    logic                            r_div_err, n_div_err;
    logic                            r_fin, n_fin;
    logic                            r_sign_fix, n_sign_fix;
    logic                            r_neg, n_neg;
    logic [kic_pkg::STEP_W-1:0]      r_step, n_step;
    logic [W-1:0]                    r_wa, n_wa;   // multiplicand / divisor
    logic [W-1:0]                    r_wb, n_wb;   // multiplier / quotient
    logic [W-1:0]                    r_wc, n_wc;   // product / remainder
    logic                            r_out_valid, n_out_valid;
    logic signed [W-1:0]             r_out_value, n_out_value;
    kic_pkg::t_status                r_out_status, n_out_status;

    logic         in_acc;
    logic         out_free;
    logic         is_digit;
    logic         is_op_key;
    logic         last_step;
    logic [W-1:0] mul_sum;
    logic [W:0]   rem_shift;
    logic [W:0]   rem_diff;
    logic [W-1:0] acc_mag;
    logic [W-1:0] num_mag;

    assign in_acc    = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;
    assign is_digit  = (i_key_code >= kic_pkg::KEY_ZERO) && (i_key_code <= kic_pkg::KEY_NINE);
    assign is_op_key = (i_key_code >= kic_pkg::KEY_OP_FIRST)
                    && (i_key_code <= kic_pkg::KEY_OP_LAST);
    assign last_step = (r_step == kic_pkg::STEP_W'(W - 1));
    assign mul_sum   = r_wc + (r_wb[0] ? r_wa : '0);
    assign rem_shift = {r_wc, r_wb[W-1]};
    assign rem_diff  = rem_shift - {1'b0, r_wa};
    assign acc_mag   = r_acc[W-1] ? (~r_acc + 1'b1) : r_acc;
    assign num_mag   = r_number[W-1] ? (~r_number + 1'b1) : r_number;

    always_comb begin
        n_state      = r_state;
        n_enter_key  = i_cfg_wr_en ? i_cfg_wr_data : r_enter_key;
        n_phase      = r_phase;
        n_digit_cnt  = r_digit_cnt;
        n_number     = r_number;
        n_term_cnt   = r_term_cnt;
        n_acc        = r_acc;
        n_op         = r_op;
        n_div_err    = r_div_err;
        n_fin        = r_fin;
        n_sign_fix   = r_sign_fix;
        n_neg        = r_neg;
        n_step       = r_step;
        n_wa         = r_wa;
        n_wb         = r_wb;
        n_wc         = r_wc;
        n_out_valid  = r_out_valid && i_stall;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    // fold the term on '=' with digits, or on Enter with digits
                    if (r_phase == kic_pkg::PHASE_NUMBER
                        && r_digit_cnt != '0
                        && (i_key_code == kic_pkg::KEY_FINISH
                            || i_key_code == r_enter_key)) begin
                        n_fin       = (i_key_code == kic_pkg::KEY_FINISH);
                        n_phase     = n_fin ? r_phase : kic_pkg::PHASE_OP;
                        n_term_cnt  = r_term_cnt + 1'b1;
                        n_digit_cnt = '0;
                        n_number    = '0;
                        n_state     = n_fin ? S_FIN : S_IDLE;
                        if (r_term_cnt == '0) begin
                            n_acc = r_number;
                        end else if (!r_div_err) begin
                            unique case (r_op)
                                kic_pkg::OP_ADD: n_acc = r_acc + r_number;
                                kic_pkg::OP_SUB: n_acc = r_acc - r_number;
                                kic_pkg::OP_MUL: begin
                                    n_wa    = r_acc;
                                    n_wb    = r_number;
                                    n_wc    = '0;
                                    n_step  = '0;
                                    n_state = S_MUL;
                                end
                                default: begin
                                    if (r_number == '0) begin
                                        n_div_err = 1'b1;
                                    end else begin
                                        n_wa       = num_mag;
                                        n_wb       = acc_mag;
                                        n_wc       = '0;
                                        n_neg      = r_acc[W-1] ^ r_number[W-1];
                                        n_step     = '0;
                                        n_sign_fix = 1'b0;
                                        n_state    = S_DIV;
                                    end
                                end
                            endcase
                        end
                    end else if (i_key_code == kic_pkg::KEY_FINISH) begin
                        n_state = S_FIN;
                    end else if (r_phase == kic_pkg::PHASE_NUMBER) begin
                        if (is_digit && r_digit_cnt < kic_pkg::DIGIT_W'(MAX_DIGITS)) begin
                            // x*10 + d as (x<<3) + (x<<1) + d
                            n_number    = {r_number[W-4:0], 3'b000}
                                        + {r_number[W-2:0], 1'b0}
                                        + W'(i_key_code[3:0]);
                            n_digit_cnt = r_digit_cnt + 1'b1;
                        end
                    end else if (is_op_key) begin
                        n_op    = kic_pkg::t_op'(i_key_code - kic_pkg::KEY_OP_FIRST);
                        n_phase = kic_pkg::PHASE_NUMBER;
                        if (r_term_cnt >= kic_pkg::TERM_W'(MAX_TERMS)) begin
                            n_state = S_FIN;
                        end
                    end
                end
            end
            S_MUL: begin
                n_wc   = mul_sum;
                n_wa   = {r_wa[W-2:0], 1'b0};
                n_wb   = {1'b0, r_wb[W-1:1]};
                n_step = r_step + 1'b1;
                if (last_step) begin
                    n_acc   = mul_sum;
                    n_state = r_fin ? S_FIN : S_IDLE;
                end
            end
            S_DIV: begin
                if (r_sign_fix) begin
                    n_acc   = r_neg ? (~r_wb + 1'b1) : r_wb;
                    n_state = r_fin ? S_FIN : S_IDLE;
                end else begin
                    n_wc   = rem_diff[W] ? rem_shift[W-1:0] : rem_diff[W-1:0];
                    n_wb   = {r_wb[W-2:0], !rem_diff[W]};
                    n_step = r_step + 1'b1;
                    if (last_step) begin
                        n_sign_fix = 1'b1;
                    end
                end
            end
            default: begin
                // hold here until the result register can take the transaction
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_term_cnt == '0) begin
                        n_out_value  = '0;
                        n_out_status = kic_pkg::ST_NO_NUM;
                    end else if (r_div_err) begin
                        n_out_value  = '0;
                        n_out_status = kic_pkg::ST_DIV_ZERO;
                    end else begin
                        n_out_value  = r_acc;
                        n_out_status = kic_pkg::ST_OK;
                    end
                    n_phase     = kic_pkg::PHASE_NUMBER;
                    n_digit_cnt = '0;
                    n_number    = '0;
                    n_term_cnt  = '0;
                    n_acc       = '0;
                    n_op        = kic_pkg::OP_ADD;
                    n_div_err   = 1'b0;
                    n_fin       = 1'b0;
                    n_state     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enter_key <= kic_pkg::ENTER_KEY_RST;
            r_phase     <= kic_pkg::PHASE_NUMBER;
            r_digit_cnt <= '0;
            r_number    <= '0;
            r_term_cnt  <= '0;
            r_acc       <= '0;
            r_op        <= kic_pkg::OP_ADD;
            r_div_err   <= 1'b0;
            r_fin       <= 1'b0;
            r_sign_fix  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_enter_key <= n_enter_key;
            r_phase     <= n_phase;
            r_digit_cnt <= n_digit_cnt;
            r_number    <= n_number;
            r_term_cnt  <= n_term_cnt;
            r_acc       <= n_acc;
            r_op        <= n_op;
            r_div_err   <= n_div_err;
            r_fin       <= n_fin;
            r_sign_fix  <= n_sign_fix;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg        <= n_neg;
        r_step       <= n_step;
        r_wa         <= n_wa;
        r_wb         <= n_wb;
        r_wc         <= n_wc;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;

    a_err_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != kic_pkg::ST_OK) |-> (o_result_value == '0))
        else $error("error status with nonzero result value");

    a_mul_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_op == kic_pkg::OP_MUL && !r_div_err))
        else $error("multiply unit running without a multiply pending");

    a_div_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_op == kic_pkg::OP_DIV && r_wa != '0))
        else $error("divide unit running without a nonzero divisor");

    a_digit_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digit_cnt <= kic_pkg::DIGIT_W'(MAX_DIGITS))
        else $error("digit count above limit");

    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && out_free) |=> (o_valid && r_term_cnt == '0 && !o_stall))
        else $error("finish did not emit and clear");

endmodule

### tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RESET_CYCLES  = 7;
    localparam int unsigned SETTLE_CYCLES = 40;   // covers the longest term and the finish state
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned PHASES        = 8;
    localparam int unsigned PHASE_KEYS    = 180;
    localparam int unsigned LONG_TERMS    = kic_pkg::MAX_TERMS_DEF + 1;

    typedef struct packed {
        logic signed [kic_pkg::DATA_W-1:0] value;
        kic_pkg::t_status                  status;
    } t_answer;

    typedef struct packed {
        logic [kic_pkg::KEY_W-1:0] key;
        logic                      typed;
        t_answer                   ans;
    } t_stim_row;

    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              i_valid       = 1'b0;
    logic [kic_pkg::KEY_W-1:0]         i_key_code    = '0;
    logic                              i_stall       = 1'b0;
    logic                              i_cfg_wr_en   = 1'b0;
    logic [kic_pkg::KEY_W-1:0]         i_cfg_wr_data = '0;
    logic                              o_stall;
    logic                              o_valid;
    logic signed [kic_pkg::DATA_W-1:0] o_result_value;
    kic_pkg::t_status                  o_status;

    // predicted calculator state
    logic                        calc_phase;
    logic [kic_pkg::DIGIT_W-1:0] calc_digits;
    logic [kic_pkg::DATA_W-1:0]  calc_entry;
    logic [kic_pkg::TERM_W-1:0]  calc_terms;
    logic [kic_pkg::DATA_W-1:0]  calc_acc;
    kic_pkg::t_op                calc_op;
    logic                        calc_div_err;
    logic [kic_pkg::KEY_W-1:0]   calc_enter;

    t_answer     awaited_answers[$];
    t_stim_row   directed_rows[$];
    int unsigned keys_sent  = 0;
    int unsigned error_count = 0;
    bit          calm       = 1'b0;
    bit          hold_req   = 1'b0;

    keypad_integer_calculator DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_key_code     (i_key_code),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [kic_pkg::KEY_W-1:0] digit_key(input int unsigned d);
        return kic_pkg::KEY_ZERO + kic_pkg::KEY_W'(d);
    endfunction

    function automatic logic [kic_pkg::KEY_W-1:0] op_key(input kic_pkg::t_op op);
        return kic_pkg::KEY_OP_FIRST + kic_pkg::KEY_W'(op);
    endfunction

    function automatic void clear_calc();
        calc_phase   = kic_pkg::PHASE_NUMBER;
        calc_digits  = '0;
        calc_entry   = '0;
        calc_terms   = '0;
        calc_acc     = '0;
        calc_op      = kic_pkg::OP_ADD;
        calc_div_err = 1'b0;
    endfunction

    function automatic logic [kic_pkg::DATA_W-1:0] quotient_toward_zero(
        input logic [kic_pkg::DATA_W-1:0] a,
        input logic [kic_pkg::DATA_W-1:0] b);
        logic [kic_pkg::DATA_W-1:0] ma;
        logic [kic_pkg::DATA_W-1:0] mb;
        logic [kic_pkg::DATA_W-1:0] q;
        ma = a[kic_pkg::DATA_W-1] ? -a : a;
        mb = b[kic_pkg::DATA_W-1] ? -b : b;
        q  = ma / mb;
        return (a[kic_pkg::DATA_W-1] ^ b[kic_pkg::DATA_W-1]) ? -q : q;
    endfunction

    function automatic void fold_term();
        if (calc_terms == 0) begin
            calc_acc = calc_entry;
        end else if (!calc_div_err) begin
            case (calc_op)
                kic_pkg::OP_ADD: calc_acc = calc_acc + calc_entry;
                kic_pkg::OP_SUB: calc_acc = calc_acc - calc_entry;
                kic_pkg::OP_MUL: calc_acc = calc_acc * calc_entry;
                default: begin
                    if (calc_entry == 0) calc_div_err = 1'b1;
                    else calc_acc = quotient_toward_zero(calc_acc, calc_entry);
                end
            endcase
        end
        calc_terms  = calc_terms + 1'b1;
        calc_digits = '0;
        calc_entry  = '0;
    endfunction

    function automatic t_answer close_expression();
        t_answer ans;
        if (calc_terms == 0) begin
            ans.value  = '0;
            ans.status = kic_pkg::ST_NO_NUM;
        end else if (calc_div_err) begin
            ans.value  = '0;
            ans.status = kic_pkg::ST_DIV_ZERO;
        end else begin
            ans.value  = calc_acc;
            ans.status = kic_pkg::ST_OK;
        end
        clear_calc();
        return ans;
    endfunction

    function automatic void calc_key(input logic [kic_pkg::KEY_W-1:0] key, output bit produced,
                                     output t_answer ans);
        produced = 1'b0;
        ans      = '0;
        if (calc_phase == kic_pkg::PHASE_NUMBER) begin
            if (key == kic_pkg::KEY_FINISH) begin
                if (calc_digits != 0) fold_term();
                ans      = close_expression();
                produced = 1'b1;
            end else if (key == calc_enter && calc_digits != 0) begin
                fold_term();
                calc_phase = kic_pkg::PHASE_OP;
            end else if (key >= kic_pkg::KEY_ZERO && key <= kic_pkg::KEY_NINE
                         && calc_digits < kic_pkg::MAX_DIGITS_DEF) begin
                calc_entry  = calc_entry * 32'd10
                            + kic_pkg::DATA_W'(key - kic_pkg::KEY_ZERO);
                calc_digits = calc_digits + 1'b1;
            end
        end else if (key == kic_pkg::KEY_FINISH) begin
            ans      = close_expression();
            produced = 1'b1;
        end else if (key >= kic_pkg::KEY_OP_FIRST && key <= kic_pkg::KEY_OP_LAST) begin
            calc_op    = 2'(key - kic_pkg::KEY_OP_FIRST);
            calc_phase = kic_pkg::PHASE_NUMBER;
            if (calc_terms >= kic_pkg::MAX_TERMS_DEF) begin
                ans      = close_expression();
                produced = 1'b1;
            end
        end
    endfunction

    task automatic send_key(input logic [kic_pkg::KEY_W-1:0] key, input bit typed,
                            input t_answer typed_ans);
        bit      produced;
        t_answer ans;
        if (!calm) begin
            while ($urandom_range(0, 99) < 21) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid    <= 1'b1;
        i_key_code <= key;
        do @(posedge i_clk); while (o_stall);
        calc_key(key, produced, ans);
        if (typed) awaited_answers.push_back(typed_ans);
        else if (produced) awaited_answers.push_back(ans);
    endtask

    task automatic press(input logic [kic_pkg::KEY_W-1:0] key);
        send_key(key, 1'b0, '0);
        keys_sent++;
    endtask

    task automatic type_term();
        logic [kic_pkg::KEY_W-1:0]  keys[$];
        logic [kic_pkg::DATA_W-1:0] v;
        int unsigned                pick;
        pick = $urandom_range(0, 9);
        if (pick == 9) begin
            // overlong digit string, the tail is dropped
            repeat ($urandom_range(kic_pkg::MAX_DIGITS_DEF + 1, kic_pkg::MAX_DIGITS_DEF + 4))
                press(digit_key($urandom_range(0, 9)));
            return;
        end
        case (pick)
            5, 6: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h0000_0000;
                    1: v = 32'h0000_0001;
                    2: v = 32'h7FFF_FFFF;
                    3: v = 32'h8000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            7: v = $urandom();
            8: v = $urandom_range(0, 99);
            default: v = $urandom_range(0, 999);
        endcase
        do begin
            keys.push_front(digit_key(v % 10));
            v = v / 10;
        end while (v != 0);
        if (pick == 8) repeat ($urandom_range(1, 4)) keys.push_front(kic_pkg::KEY_ZERO);
        foreach (keys[i]) press(keys[i]);
    endtask

    task automatic type_expression(input int unsigned n_terms, input bit one_digit);
        int unsigned ending;
        for (int unsigned t = 0; t < n_terms; t++) begin
            if (t != 0) press(op_key(2'($urandom_range(0, 3))));
            if (one_digit) press(digit_key($urandom_range(0, 9)));
            else type_term();
            if ($urandom_range(0, 9) == 0)
                send_key(kic_pkg::KEY_W'($urandom_range(0, 255)), 1'b0, '0);
            if (t + 1 < n_terms) press(calc_enter);
        end
        ending = $urandom_range(0, 9);
        if (ending < 3) begin
            press(kic_pkg::KEY_FINISH);
        end else begin
            press(calc_enter);
            // drop a pending operation on an empty term
            if (ending >= 8) press(op_key(2'($urandom_range(0, 3))));
            press(kic_pkg::KEY_FINISH);
        end
    endtask

    task automatic key_noise();
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 3))
                0: send_key(kic_pkg::KEY_W'($urandom_range(0, 255)), 1'b0, '0);
                1: send_key(digit_key($urandom_range(0, 9)), 1'b0, '0);
                2: send_key(op_key(2'($urandom_range(0, 3))), 1'b0, '0);
                default: send_key(calc_enter, 1'b0, '0);
            endcase
        end
    endtask

    task automatic write_enter(input logic [kic_pkg::KEY_W-1:0] code);
        i_valid <= 1'b0;
        while (awaited_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= code;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        calc_enter = code;
    endtask

    function automatic void add_row(input logic [kic_pkg::KEY_W-1:0] key, input bit typed,
                                    input logic signed [kic_pkg::DATA_W-1:0] value,
                                    input kic_pkg::t_status status);
        t_stim_row row;
        row.key        = key;
        row.typed      = typed;
        row.ans.value  = value;
        row.ans.status = status;
        directed_rows.push_back(row);
    endfunction

    function automatic void build_directed();
        add_row(8'h00, 1'b0, 0, kic_pkg::ST_OK);
        add_row(kic_pkg::ENTER_KEY_RST, 1'b0, 0, kic_pkg::ST_OK);  // Enter on an empty term
        add_row(kic_pkg::KEY_FINISH, 1'b1, 0, kic_pkg::ST_NO_NUM);
        add_row(digit_key(8), 1'b0, 0, kic_pkg::ST_OK);
        add_row(kic_pkg::ENTER_KEY_RST, 1'b0, 0, kic_pkg::ST_OK);
        add_row(8'hFF, 1'b0, 0, kic_pkg::ST_OK);                  // meaningless in operation phase
        add_row(digit_key(0), 1'b0, 0, kic_pkg::ST_OK);
        add_row(op_key(kic_pkg::OP_MUL), 1'b0, 0, kic_pkg::ST_OK);
        add_row(kic_pkg::KEY_FINISH, 1'b1, 8, kic_pkg::ST_OK);     // multiply is dropped
        add_row(digit_key(6), 1'b0, 0, kic_pkg::ST_OK);
        add_row(kic_pkg::ENTER_KEY_RST, 1'b0, 0, kic_pkg::ST_OK);
        add_row(op_key(kic_pkg::OP_SUB), 1'b0, 0, kic_pkg::ST_OK);
        add_row(digit_key(9), 1'b0, 0, kic_pkg::ST_OK);
        add_row(kic_pkg::ENTER_KEY_RST, 1'b0, 0, kic_pkg::ST_OK);
        add_row(op_key(kic_pkg::OP_MUL), 1'b0, 0, kic_pkg::ST_OK);
        add_row(digit_key(7), 1'b0, 0, kic_pkg::ST_OK);
        add_row(kic_pkg::ENTER_KEY_RST, 1'b0, 0, kic_pkg::ST_OK);
        add_row(op_key(kic_pkg::OP_DIV), 1'b0, 0, kic_pkg::ST_OK);
        add_row(digit_key(4), 1'b0, 0, kic_pkg::ST_OK);
        add_row(kic_pkg::ENTER_KEY_RST, 1'b0, 0, kic_pkg::ST_OK);
        add_row(kic_pkg::KEY_FINISH, 1'b0, 0, kic_pkg::ST_OK);
        add_row(digit_key(5), 1'b0, 0, kic_pkg::ST_OK);
        add_row(kic_pkg::ENTER_KEY_RST, 1'b0, 0, kic_pkg::ST_OK);
        add_row(op_key(kic_pkg::OP_DIV), 1'b0, 0, kic_pkg::ST_OK);
        add_row(digit_key(0), 1'b0, 0, kic_pkg::ST_OK);
        add_row(kic_pkg::ENTER_KEY_RST, 1'b0, 0, kic_pkg::ST_OK);
        add_row(op_key(kic_pkg::OP_ADD), 1'b0, 0, kic_pkg::ST_OK);
        add_row(digit_key(5), 1'b0, 0, kic_pkg::ST_OK);
        add_row(kic_pkg::KEY_FINISH, 1'b1, 0, kic_pkg::ST_DIV_ZERO);
    endfunction

    initial begin : result_sink
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_stall <= !calm && ($urandom_range(0, 99) < 21);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_answer want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_answers.size() == 0) begin
                $error("result transaction with none pending: value %0d status %0d",
                       o_result_value, o_status);
                error_count++;
            end else begin
                want = awaited_answers.pop_front();
                if (o_result_value !== want.value) begin
                    $error("result_value: expected %0d, got %0d", want.value, o_result_value);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned target;
        logic [kic_pkg::KEY_W-1:0] code;
        clear_calc();
        calc_enter = kic_pkg::ENTER_KEY_RST;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        build_directed();
        foreach (directed_rows[i])
            send_key(directed_rows[i].key, directed_rows[i].typed, directed_rows[i].ans);
        for (int unsigned p = 0; p < PHASES; p++) begin
            if (p != 0) begin
                case (p)
                    1: code = 8'h00;
                    2: code = 8'hFF;
                    3: code = kic_pkg::KEY_FINISH;          // Enter collides with finish
                    4: code = digit_key(7);                 // Enter collides with a digit
                    5: code = op_key(kic_pkg::OP_SUB);      // digit and operation key at once
                    6: code = kic_pkg::ENTER_KEY_RST;
                    default: code = kic_pkg::KEY_W'($urandom_range(0, 255));
                endcase
                write_enter(code);
            end
            calm = (p == 3);
            // hold the result side while keys keep coming
            if (p == 2) hold_req = 1'b1;
            target = keys_sent + PHASE_KEYS;
            if (p == 1 || p == 6) type_expression(LONG_TERMS, 1'b1);
            while (keys_sent < target) begin
                if ($urandom_range(0, 4) == 0) key_noise();
                else type_expression($urandom_range(1, 6), 1'b0);
            end
            press(kic_pkg::KEY_FINISH);
        end
        i_valid <= 1'b0;
        calm = 1'b0;
        while (awaited_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #8_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
